>>> rtl/pahp_pkg.sv
package pahp_pkg;

	localparam int unsigned MAX_STUFFING_END_DEF = 24;

	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FORMAT_W = 3;
	localparam int unsigned LAYOUT_W = 3;
	localparam int unsigned RATE_W   = 2;
	localparam int unsigned SIZE_W   = 17;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned LEN_W    = 16;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_START   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXCESS_STUFF = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_MARKER  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_AUDIO   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BEYOND_PKT  = 3'd6;

	// audio format codes
	localparam logic [FORMAT_W-1:0] FMT_NONE    = 3'd0;
	localparam logic [FORMAT_W-1:0] FMT_MPA     = 3'd1;
	localparam logic [FORMAT_W-1:0] FMT_AC3     = 3'd2;
	localparam logic [FORMAT_W-1:0] FMT_DTS     = 3'd3;
	localparam logic [FORMAT_W-1:0] FMT_PCM16BE = 3'd4;

	localparam logic [7:0] SID_PRIVATE1   = 8'hbd;
	localparam logic [7:0] SID_PRIVATE2   = 8'hbf;
	localparam logic [7:0] SID_MIN        = 8'hb9;
	localparam logic [7:0] SID_AUDIO_MASK = 8'he0;
	localparam logic [7:0] SID_AUDIO      = 8'hc0;
	localparam logic [7:0] SUB_MASK       = 8'hf8;
	localparam logic [7:0] SUB_AC3        = 8'h80;
	localparam logic [7:0] SUB_DTS        = 8'h88;
	localparam logic [7:0] SUB_LPCM       = 8'ha0;
	localparam logic [7:0] MARK_NO_TS     = 8'h0f;

	typedef struct packed {
		logic [FORMAT_W-1:0] fmt;
		logic [LAYOUT_W-1:0] layout;
		logic [RATE_W-1:0]   rate;
	} audio_class_t;

	function automatic audio_class_t classify(input logic [7:0] sid, input logic [7:0] sub,
		input logic [7:0] info);
		audio_class_t c;
		c = '0;
		if ((sid & SID_AUDIO_MASK) == SID_AUDIO) begin
			c.fmt = FMT_MPA;
		end else if ((sub & SUB_MASK) == SUB_AC3) begin
			c.fmt = FMT_AC3;
		end else if ((sub & SUB_MASK) == SUB_DTS) begin
			c.fmt = FMT_DTS;
		end else if ((sub & SUB_MASK) == SUB_LPCM) begin
			// quantization in [7:6], rate in [5:4], channels minus one in [2:0]
			if (info[7:6] != 2'b11 && info[2:0] < 3'd6 && !info[5]) begin
				c.fmt    = FMT_PCM16BE + {1'b0, info[7:6]};
				c.layout = info[2:0] + 3'd1;
				c.rate   = {1'b0, info[4]} + 2'd1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/pes_audio_header_parser.sv
// PES audio header parser. Feed the bytes of one program-stream PES packet buffer, one byte
// per transaction starting at the 00 00 01 prefix, with last set on the buffer's final byte.
// One byte is accepted per cycle while in_ready is high, and the whole header state machine
// advances once per byte. The single result is registered and is valid the cycle after the
// last byte is accepted; the next buffer may start in that same cycle, and input is held off
// only while a result waits and out_ready is low. A result with a nonzero status carries zero
// format, layout, rate, body offset and body length fields. If the buffer ends before the
// header could be fully parsed, status is truncated.
module pes_audio_header_parser #(
	parameter int unsigned MAX_STUFFING_END = pahp_pkg::MAX_STUFFING_END_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pahp_pkg::STATUS_W-1:0] status,
	output logic [7:0]                    stream_id,
	output logic [7:0]                    substream_id,
	output logic [pahp_pkg::FORMAT_W-1:0] audio_format,
	output logic [pahp_pkg::LAYOUT_W-1:0] channel_layout,
	output logic [pahp_pkg::RATE_W-1:0]   sample_rate_code,
	output logic [pahp_pkg::SIZE_W-1:0]   pes_size,
	output logic [pahp_pkg::POS_W-1:0]    body_offset,
	output logic [pahp_pkg::SIZE_W-1:0]   body_length
);
	import pahp_pkg::*;

	localparam logic [3:0] PH_SYNC  = 4'd0;
	localparam logic [3:0] PH_LEN   = 4'd1;
	localparam logic [3:0] PH_FIRST = 4'd2;
	localparam logic [3:0] PH_M2    = 4'd3;
	localparam logic [3:0] PH_STUFF = 4'd4;
	localparam logic [3:0] PH_MARK  = 4'd5;
	localparam logic [3:0] PH_HDR   = 4'd6;
	localparam logic [3:0] PH_TAIL  = 4'd7;
	localparam logic [3:0] PH_DONE  = 4'd8;

	localparam logic [POS_W-1:0] CNT_MAX   = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] STUFF_END = POS_W'(MAX_STUFFING_END);

	logic [3:0]          phase_q, n_phase;
	logic [POS_W-1:0]    byte_count_q, n_count;
	logic [7:0]          stream_q, n_stream;
	logic [LEN_W-1:0]    length_q, n_length;
	logic [POS_W-1:0]    target_q, n_target;
	logic [7:0]          sub_q, n_sub;
	logic [POS_W-1:0]    sub_hdr_q, n_sub_hdr;
	logic [7:0]          lpcm_q, n_lpcm;
	logic [STATUS_W-1:0] pending_q, n_pending;
	logic                decided_q, n_decided;

	logic                do_stuff, do_marker, do_decide;
	audio_class_t        dec_cls, out_cls;
	logic [POS_W:0]      dec_pos;
	logic [STATUS_W-1:0] r_status;
	logic [SIZE_W-1:0]   r_pkt, r_psize;
	logic [POS_W-1:0]    r_ppos;
	logic                in_fire;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [7:0]          stream_id_q, substream_id_q;
	logic [FORMAT_W-1:0] format_q;
	logic [LAYOUT_W-1:0] layout_q;
	logic [RATE_W-1:0]   rate_q;
	logic [SIZE_W-1:0]   pkt_q, psize_q;
	logic [POS_W-1:0]    ppos_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		n_phase   = phase_q;
		n_stream  = stream_q;
		n_length  = length_q;
		n_target  = target_q;
		n_sub     = sub_q;
		n_sub_hdr = sub_hdr_q;
		n_lpcm    = lpcm_q;
		n_pending = pending_q;
		n_decided = decided_q;
		do_stuff  = 1'b0;
		do_marker = 1'b0;
		do_decide = 1'b0;
		n_count   = (byte_count_q < CNT_MAX) ? byte_count_q + POS_W'(1) : CNT_MAX;
		dec_cls   = classify(stream_q, sub_q, lpcm_q);
		dec_pos   = {1'b0, target_q} + ((dec_cls.fmt >= FMT_PCM16BE) ? (POS_W+1)'(3) : '0);

		if (!decided_q) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (byte_count_q < POS_W'(2)) begin
						if (data_byte != 8'd0) begin
							n_pending = ST_BAD_START;
							n_decided = 1'b1;
						end
					end else if (byte_count_q == POS_W'(2)) begin
						if (data_byte != 8'd1) begin
							n_pending = ST_BAD_START;
							n_decided = 1'b1;
						end
					end else begin
						n_stream = data_byte;
						if (data_byte < SID_MIN) begin
							n_pending = ST_BAD_START;
							n_decided = 1'b1;
						end else begin
							n_phase = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (byte_count_q == POS_W'(4)) begin
						n_length = {data_byte, 8'd0};
					end else begin
						n_length = length_q | {8'd0, data_byte};
						if (stream_q == SID_PRIVATE2) begin
							n_target = POS_W'(6);
							n_phase  = PH_HDR;
						end else begin
							n_phase = PH_FIRST;
						end
					end
				end
				PH_FIRST: begin
					if (data_byte[7:6] == 2'b10) n_phase = PH_M2;
					else do_stuff = 1'b1;
				end
				PH_M2: begin
					if (byte_count_q == POS_W'(8)) begin
						n_target = {1'b0, data_byte} + POS_W'(9);
						n_phase  = PH_HDR;
					end
				end
				PH_STUFF: do_stuff = 1'b1;
				PH_MARK: begin
					if (byte_count_q == target_q) do_marker = 1'b1;
				end
				PH_HDR: begin
					if (byte_count_q == target_q) begin
						if (stream_q == SID_PRIVATE1) begin
							n_sub     = data_byte;
							n_sub_hdr = byte_count_q + POS_W'(1);
							n_target  = byte_count_q + POS_W'(4);
						end else begin
							n_sub     = 8'd0;
							n_sub_hdr = '0;
						end
						n_phase = PH_TAIL;
					end
				end
				PH_TAIL: begin
					if (byte_count_q == target_q + POS_W'(1)) n_lpcm = data_byte;
					if (byte_count_q == target_q + POS_W'(3)) do_decide = 1'b1;
				end
				default: ;
			endcase

			// MPEG-1: stuffing, then STD buffer field, then the timestamp marker
			if (do_stuff) begin
				if (byte_count_q >= STUFF_END) begin
					n_pending = ST_EXCESS_STUFF;
					n_decided = 1'b1;
				end else if (data_byte == 8'hff) begin
					n_phase = PH_STUFF;
				end else if (data_byte[7:6] == 2'b01) begin
					n_target = byte_count_q + POS_W'(2);
					n_phase  = PH_MARK;
				end else begin
					do_marker = 1'b1;
				end
			end

			if (do_marker) begin
				priority if (data_byte[7:4] == 4'h2) begin
					n_target = byte_count_q + POS_W'(5);
					n_phase  = PH_HDR;
				end else if (data_byte[7:4] == 4'h3) begin
					n_target = byte_count_q + POS_W'(10);
					n_phase  = PH_HDR;
				end else if (data_byte == MARK_NO_TS) begin
					n_target = byte_count_q + POS_W'(1);
					n_phase  = PH_HDR;
				end else begin
					n_pending = ST_BAD_MARKER;
					n_decided = 1'b1;
				end
			end

			if (do_decide) begin
				n_decided = 1'b1;
				if (dec_cls.fmt == FMT_NONE) n_pending = ST_NOT_AUDIO;
				else if ({{(SIZE_W-POS_W-1){1'b0}}, dec_pos} >= {1'b0, length_q} + SIZE_W'(6))
					n_pending = ST_BEYOND_PKT;
				else n_pending = ST_OK;
			end

			if (n_decided) n_phase = PH_DONE;
		end

		// result as seen after this byte
		r_status = n_decided ? n_pending : ST_TRUNCATED;
		r_pkt    = {1'b0, n_length} + SIZE_W'(6);
		out_cls  = classify(n_stream, n_sub, n_lpcm);
		r_ppos   = n_target + ((out_cls.fmt >= FMT_PCM16BE) ? POS_W'(3) : '0);
		r_psize  = r_pkt - {{(SIZE_W-POS_W){1'b0}}, r_ppos};
		if (r_status != ST_OK) begin
			out_cls = '0;
			r_ppos  = '0;
			r_psize = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC;
			byte_count_q <= '0;
			stream_q     <= '0;
			length_q     <= '0;
			target_q     <= '0;
			sub_q        <= '0;
			sub_hdr_q    <= '0;
			lpcm_q       <= '0;
			pending_q    <= ST_OK;
			decided_q    <= 1'b0;
		end else if (in_fire) begin
			if (last) begin
				// start over for the next buffer
				phase_q      <= PH_SYNC;
				byte_count_q <= '0;
				stream_q     <= '0;
				length_q     <= '0;
				target_q     <= '0;
				sub_q        <= '0;
				sub_hdr_q    <= '0;
				lpcm_q       <= '0;
				pending_q    <= ST_OK;
				decided_q    <= 1'b0;
			end else begin
				phase_q      <= n_phase;
				byte_count_q <= n_count;
				stream_q     <= n_stream;
				length_q     <= n_length;
				target_q     <= n_target;
				sub_q        <= n_sub;
				sub_hdr_q    <= n_sub_hdr;
				lpcm_q       <= n_lpcm;
				pending_q    <= n_pending;
				decided_q    <= n_decided;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last) begin
			status_q       <= r_status;
			stream_id_q    <= n_stream;
			substream_id_q <= n_sub;
			format_q       <= out_cls.fmt;
			layout_q       <= out_cls.layout;
			rate_q         <= out_cls.rate;
			pkt_q          <= r_pkt;
			ppos_q         <= r_ppos;
			psize_q        <= r_psize;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign stream_id        = stream_id_q;
	assign substream_id     = substream_id_q;
	assign audio_format     = format_q;
	assign channel_layout   = layout_q;
	assign sample_rate_code = rate_q;
	assign pes_size         = pkt_q;
	assign body_offset      = ppos_q;
	assign body_length      = psize_q;

	a_ok_has_format: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> audio_format != FMT_NONE)
		else $error("ok result without an audio format");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> body_offset == '0 && body_length == '0
			&& audio_format == FMT_NONE)
		else $error("failed result carries payload fields");

	a_decided_done: assert property (@(posedge clk) disable iff (!arst_n)
		decided_q |-> phase_q == PH_DONE)
		else $error("decision taken but parse still running");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> byte_count_q == '0 && !decided_q && out_valid)
		else $error("state not cleared after last byte");

endmodule
